FILE: sv/tgknt_pkg.sv
// shared constants, types and helper functions of the grid key note tracker
package tgknt_pkg;

    localparam int BLOB_SLOTS = 16;
    localparam int SLOT_W     = $clog2(BLOB_SLOTS);
    localparam int MAX_KEYS   = 256;
    localparam int KEY_W      = $clog2(MAX_KEYS);
    localparam int COORD_W    = 16;
    localparam int SCALE_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = COORD_W + SCALE_W;
    localparam int CELL_W     = PROD_W - FRAC_W;
    localparam int COUNT_W    = 5;
    localparam int MAX_COUNT  = 16;
    localparam int IDX_W      = 4;
    localparam int SUM_W      = IDX_W + COUNT_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_LEFT    = 4'd0,
        REG_GRID_RIGHT   = 4'd1,
        REG_GRID_TOP     = 4'd2,
        REG_GRID_BOTTOM  = 4'd3,
        REG_COLUMN_COUNT = 4'd4,
        REG_ROW_COUNT    = 4'd5,
        REG_COLUMN_SCALE = 4'd6,
        REG_ROW_SCALE    = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_KEY,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic take;
        logic capture;
        logic mult;
        logic decide;
        logic push_off;
        logic push_on;
    } dp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic pend_off;
        logic pend_on;
        logic out_free;
    } dp_stat_t;

    // zero counts as one, anything above the maximum as the maximum
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] r;
        if (n == '0)
            r = COUNT_W'(1);
        else if (n > COUNT_W'(MAX_COUNT))
            r = COUNT_W'(MAX_COUNT);
        else
            r = n;
        return r;
    endfunction

    // cell number limited to the last column or row
    function automatic logic [IDX_W-1:0] clamp_cell(input logic [CELL_W-1:0] cell_num,
                                                    input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] lim;
        logic [IDX_W-1:0]   r;
        lim = cnt - COUNT_W'(1);
        if (cell_num > CELL_W'(lim))
            r = lim[IDX_W-1:0];
        else
            r = cell_num[IDX_W-1:0];
        return r;
    endfunction

endpackage

FILE: sv/tgknt_ifs.sv
// channel interfaces: blob input, note output and register write
interface tgknt_blob_if;
    logic                            valid;
    logic                            ready;
    logic [tgknt_pkg::SLOT_W-1:0]    blob_slot;
    logic [tgknt_pkg::COORD_W-1:0]   centroid_x;
    logic [tgknt_pkg::COORD_W-1:0]   centroid_y;
    logic                            blob_alive;

    modport source (output valid, blob_slot, centroid_x, centroid_y, blob_alive,
                    input ready);
    modport sink   (input valid, blob_slot, centroid_x, centroid_y, blob_alive,
                    output ready);
endinterface

interface tgknt_note_if;
    logic                          valid;
    logic                          ready;
    logic [tgknt_pkg::KEY_W-1:0]   key_index;
    logic                          note_on;
    logic                          last_of_run;

    modport source (output valid, key_index, note_on, last_of_run, input ready);
    modport sink   (input valid, key_index, note_on, last_of_run, output ready);
endinterface

interface tgknt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tgknt_pkg::CFG_IDX_W-1:0]   index;
    logic [tgknt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/touch_grid_key_note_tracker_top.sv
// top level of the grid key note tracker: controller plus datapath
// an input word is taken in the idle cycle, products are registered in the next,
// the key and note decision in the one after, and the send state then pushes the
// old key's note-off and the new key's note-on into the output register, waiting
// while it is full; the next word is taken only back in the idle state
// reset clears the controller, the registers to their defaults and all held keys
module touch_grid_key_note_tracker_top (
    input  logic         clk,
    input  logic         rst_n,
    tgknt_blob_if.sink   blob,
    tgknt_note_if.source note,
    tgknt_cfg_if.sink    cfg
);
    import tgknt_pkg::*;

    // commands from the controller, status back from the datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // state machine: idle, multiply, decide, send no, one or two words
    tgknt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // config registers, multipliers, held-key store and output register
    tgknt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .blob  (blob),
        .note  (note),
        .cfg   (cfg)
    );

endmodule

FILE: sv/tgknt_ctrl.sv
// sequencing state machine of the grid key note tracker
module tgknt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  tgknt_pkg::dp_stat_t stat,
    output tgknt_pkg::dp_cmd_t  cmd
);
    import tgknt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_KEY;
            end
            ST_KEY:
            begin
                cmd.decide = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                // note-off of the old key goes out before the note-on
                priority if (stat.pend_off)
                begin
                    if (stat.out_free)
                    begin
                        cmd.push_off = 1'b1;
                        if (!stat.pend_on)
                            state_next = ST_IDLE;
                    end
                end
                else if (stat.pend_on)
                begin
                    if (stat.out_free)
                    begin
                        cmd.push_on = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/tgknt_dp.sv
// datapath: registers, key mapping, held-key store and output register
module tgknt_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  tgknt_pkg::dp_cmd_t  cmd,
    output tgknt_pkg::dp_stat_t stat,
    tgknt_blob_if.sink          blob,
    tgknt_note_if.source        note,
    tgknt_cfg_if.sink           cfg
);
    import tgknt_pkg::*;

    // configuration
    logic [COORD_W-1:0] grid_left_reg, grid_right_reg, grid_top_reg, grid_bottom_reg;
    logic [COUNT_W-1:0] column_count_reg, row_count_reg;
    logic [SCALE_W-1:0] column_scale_reg, row_scale_reg;

    // captured word
    logic [SLOT_W-1:0]  slot_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic               alive_reg;

    // products and grid test
    logic [PROD_W-1:0]  prod_x_reg, prod_y_reg;
    logic [PROD_W-1:0]  prod_x_next, prod_y_next;
    logic               inside_reg, inside_next;

    // decision
    logic [KEY_W-1:0]   old_key_reg, new_key_reg, new_key_next;
    logic               pend_off_reg, pend_on_reg;
    logic               pend_off_next, pend_on_next;

    // held-key store
    logic [KEY_W-1:0]   held_key_reg [BLOB_SLOTS];
    logic [BLOB_SLOTS-1:0] held_valid_reg;

    // output register
    logic               out_valid_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic               out_on_reg, out_last_reg;

    logic [COUNT_W-1:0] cols, rows;
    logic [IDX_W-1:0]   col, row;
    logic [SUM_W-1:0]   key_sum;
    logic               hv;
    logic [KEY_W-1:0]   hk;
    logic               hold_write;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_left_reg    <= '0;
            grid_right_reg   <= '1;
            grid_top_reg     <= '0;
            grid_bottom_reg  <= '1;
            column_count_reg <= COUNT_W'(1);
            row_count_reg    <= COUNT_W'(1);
            column_scale_reg <= SCALE_W'(256);
            row_scale_reg    <= SCALE_W'(256);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GRID_LEFT:    grid_left_reg    <= cfg.data[COORD_W-1:0];
                REG_GRID_RIGHT:   grid_right_reg   <= cfg.data[COORD_W-1:0];
                REG_GRID_TOP:     grid_top_reg     <= cfg.data[COORD_W-1:0];
                REG_GRID_BOTTOM:  grid_bottom_reg  <= cfg.data[COORD_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= cfg.data[COUNT_W-1:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg.data[COUNT_W-1:0];
                REG_COLUMN_SCALE: column_scale_reg <= cfg.data[SCALE_W-1:0];
                REG_ROW_SCALE:    row_scale_reg    <= cfg.data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign blob.ready = cmd.take;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg  <= blob.blob_slot;
            x_reg     <= blob.centroid_x;
            y_reg     <= blob.centroid_y;
            alive_reg <= blob.blob_alive;
        end
    end

    // offset times scale, one 16x24 multiplier per axis
    always_comb
    begin
        inside_next = (x_reg > grid_left_reg) && (x_reg < grid_right_reg) &&
                      (y_reg > grid_top_reg) && (y_reg < grid_bottom_reg);
        prod_x_next = PROD_W'(x_reg - grid_left_reg) * PROD_W'(column_scale_reg);
        prod_y_next = PROD_W'(y_reg - grid_top_reg) * PROD_W'(row_scale_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            inside_reg <= inside_next;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
    end

    // key from clamped cells, then the note decision against the held key
    always_comb
    begin
        cols    = clamp_count(column_count_reg);
        rows    = clamp_count(row_count_reg);
        col     = clamp_cell(prod_x_reg[PROD_W-1:FRAC_W], cols);
        row     = clamp_cell(prod_y_reg[PROD_W-1:FRAC_W], rows);
        key_sum = SUM_W'(row) * SUM_W'(cols) + SUM_W'(col);
        if (key_sum > SUM_W'(MAX_KEYS - 1))
            new_key_next = KEY_W'(MAX_KEYS - 1);
        else
            new_key_next = key_sum[KEY_W-1:0];

        hv            = held_valid_reg[slot_reg];
        hk            = held_key_reg[slot_reg];
        pend_off_next = 1'b0;
        pend_on_next  = 1'b0;
        hold_write    = 1'b0;
        if (inside_reg)
        begin
            if (alive_reg)
            begin
                if (!(hv && (hk == new_key_next)))
                begin
                    pend_off_next = hv;
                    pend_on_next  = 1'b1;
                    hold_write    = 1'b1;
                end
            end
            else
            begin
                pend_off_next = hv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            old_key_reg <= hk;
            new_key_reg <= new_key_next;
            if (hold_write)
                held_key_reg[slot_reg] <= new_key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= '0;
            pend_off_reg   <= 1'b0;
            pend_on_reg    <= 1'b0;
        end
        else if (cmd.decide)
        begin
            pend_off_reg <= pend_off_next;
            pend_on_reg  <= pend_on_next;
            if (inside_reg)
                held_valid_reg[slot_reg] <= alive_reg ? (hv || hold_write) : 1'b0;
        end
        else
        begin
            if (cmd.push_off)
                pend_off_reg <= 1'b0;
            if (cmd.push_on)
                pend_on_reg <= 1'b0;
        end
    end

    assign stat.in_valid = blob.valid;
    assign stat.pend_off = pend_off_reg;
    assign stat.pend_on  = pend_on_reg;
    assign stat.out_free = !out_valid_reg || note.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push_off || cmd.push_on)
            out_valid_reg <= 1'b1;
        else if (note.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_off)
        begin
            out_key_reg  <= old_key_reg;
            out_on_reg   <= 1'b0;
            out_last_reg <= !pend_on_reg;
        end
        else if (cmd.push_on)
        begin
            out_key_reg  <= new_key_reg;
            out_on_reg   <= 1'b1;
            out_last_reg <= 1'b1;
        end
    end

    assign note.valid       = out_valid_reg;
    assign note.key_index   = out_key_reg;
    assign note.note_on     = out_on_reg;
    assign note.last_of_run = out_last_reg;

    a_on_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_on_reg |-> out_last_reg)
        else $error("note-on word not marked last");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_off || cmd.push_on) |-> stat.out_free)
        else $error("result pushed over a waiting word");

    a_on_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_on |-> held_valid_reg[slot_reg] && (held_key_reg[slot_reg] == new_key_reg))
        else $error("note-on key differs from held key");

    a_outside_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && !inside_reg |=> !pend_off_reg && !pend_on_reg)
        else $error("blob outside grid produced a result");

endmodule

FILE: sim/tgknt_note_checker.sv
// note checker: predicts the note words of the grid key tracker and compares them
`timescale 1ns / 100ps
module tgknt_note_checker (
    input  logic  clk,
    input  logic  rst_n,
    tgknt_blob_if blob,
    tgknt_note_if note,
    tgknt_cfg_if  cfg,
    output int    mismatch_count,
    output int    due_count
);
    import tgknt_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             note_on;
        logic             last_of_run;
    } note_word_t;

    note_word_t due_notes[$];

    logic [COORD_W-1:0] left_edge, right_edge, top_edge, bottom_edge;
    logic [COUNT_W-1:0] col_reg, row_reg;
    logic [SCALE_W-1:0] col_scale, row_scale;
    logic [KEY_W-1:0]   held_key [BLOB_SLOTS];
    logic               held     [BLOB_SLOTS];

    function automatic int usable_count(input logic [COUNT_W-1:0] n);
        int c;
        c = int'(n);
        if (c < 1)
            c = 1;
        if (c > MAX_COUNT)
            c = MAX_COUNT;
        return c;
    endfunction

    // offset times scale, fraction dropped, limited to the last line of keys
    function automatic int grid_index(input logic [COORD_W-1:0] pos,
                                      input logic [COORD_W-1:0] origin,
                                      input logic [SCALE_W-1:0] scale,
                                      input int                 count);
        longint unsigned prod;
        longint unsigned idx;
        prod = (64'(pos) - 64'(origin)) * 64'(scale);
        idx  = prod >> FRAC_W;
        if (idx > longint'(count - 1))
            idx = longint'(count - 1);
        return int'(idx);
    endfunction

    task automatic reset_model();
        left_edge   = '0;
        right_edge  = '1;
        top_edge    = '0;
        bottom_edge = '1;
        col_reg     = COUNT_W'(1);
        row_reg     = COUNT_W'(1);
        col_scale   = SCALE_W'(256);
        row_scale   = SCALE_W'(256);
        for (int s = 0; s < BLOB_SLOTS; s++)
        begin
            held_key[s] = '0;
            held[s]     = 1'b0;
        end
        due_notes.delete();
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_GRID_LEFT:    left_edge   = val[COORD_W-1:0];
            REG_GRID_RIGHT:   right_edge  = val[COORD_W-1:0];
            REG_GRID_TOP:     top_edge    = val[COORD_W-1:0];
            REG_GRID_BOTTOM:  bottom_edge = val[COORD_W-1:0];
            REG_COLUMN_COUNT: col_reg     = val[COUNT_W-1:0];
            REG_ROW_COUNT:    row_reg     = val[COUNT_W-1:0];
            REG_COLUMN_SCALE: col_scale   = val[SCALE_W-1:0];
            REG_ROW_SCALE:    row_scale   = val[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    function automatic void notes_for_blob(input logic [SLOT_W-1:0]  slot,
                                           input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic               alive);
        int cols;
        int rows;
        int key;
        // edges are exclusive, an empty rectangle lets nothing in
        if (!(x > left_edge && x < right_edge && y > top_edge && y < bottom_edge))
            return;
        cols = usable_count(col_reg);
        rows = usable_count(row_reg);
        key  = grid_index(y, top_edge, row_scale, rows) * cols
             + grid_index(x, left_edge, col_scale, cols);
        if (key > MAX_KEYS - 1)
            key = MAX_KEYS - 1;
        if (alive)
        begin
            if (held[slot] && held_key[slot] == KEY_W'(key))
                return;
            if (held[slot])
                due_notes.push_back('{held_key[slot], 1'b0, 1'b0});
            due_notes.push_back('{KEY_W'(key), 1'b1, 1'b1});
            held_key[slot] = KEY_W'(key);
            held[slot]     = 1'b1;
        end
        else
        begin
            if (!held[slot])
                return;
            due_notes.push_back('{held_key[slot], 1'b0, 1'b1});
            held[slot] = 1'b0;
        end
    endfunction

    task automatic check_note();
        note_word_t got;
        note_word_t want;
        got = '{note.key_index, note.note_on, note.last_of_run};
        if (due_notes.size() == 0)
        begin
            $display("%0t: note word with none due: key %0d on %0b last %0b",
                     $time, got.key_index, got.note_on, got.last_of_run);
            mismatch_count++;
        end
        else
        begin
            want = due_notes.pop_front();
            if (got.key_index != want.key_index)
            begin
                $display("%0t: key_index expected %0d actual %0d",
                         $time, want.key_index, got.key_index);
                mismatch_count++;
            end
            if (got.note_on != want.note_on)
            begin
                $display("%0t: note_on expected %0b actual %0b",
                         $time, want.note_on, got.note_on);
                mismatch_count++;
            end
            if (got.last_of_run != want.last_of_run)
            begin
                $display("%0t: last_of_run expected %0b actual %0b",
                         $time, want.last_of_run, got.last_of_run);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            reset_model();
        else
        begin
            if (cfg.valid && cfg.ready)
                write_register(cfg.index, cfg.data);
            if (note.valid && note.ready)
                check_note();
            if (blob.valid && blob.ready)
                notes_for_blob(blob.blob_slot, blob.centroid_x, blob.centroid_y,
                               blob.blob_alive);
        end
        due_count <= due_notes.size();
    end

endmodule

FILE: sim/tb_touch_grid_key_note_tracker_top.sv
// testbench top: drives blob words and register writes into the grid key note tracker
`timescale 1ns / 100ps
module tb_touch_grid_key_note_tracker_top;
    import tgknt_pkg::*;

    // slowest run: ~860 words, each with an idle burst, its busy time and two note
    // words each behind a receiver stall, plus the long hold-off; taken several times over
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 400;
    // a word that makes no note can still be in flight when the queue empties
    localparam int SETTLE_CYCLES = 10;
    // index with no register behind it, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'hD;

    logic clk = 1'b0;
    logic rst_n;

    tgknt_blob_if blob_ch();
    tgknt_note_if note_ch();
    tgknt_cfg_if  cfg_ch();

    int mismatch_count;
    int due_count;
    int blobs_sent;
    int cycle_count;

    // idling switches, the long hold-off request is picked up by the note receiver
    bit tx_gaps;
    bit rx_gaps;
    bit hold_request;

    // grid geometry as last programmed, used only to aim the stimulus
    int g_left, g_right, g_top, g_bottom;

    touch_grid_key_note_tracker_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .blob  (blob_ch),
        .note  (note_ch),
        .cfg   (cfg_ch)
    );

    tgknt_note_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .blob           (blob_ch),
        .note           (note_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .due_count      (due_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // note receiver: ready stretches, random stall bursts, and one long hold-off on request
    initial
    begin
        note_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                note_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 2) == 0)
            begin
                note_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                note_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // one blob word; valid stays high into the next call unless an idle burst follows
    task automatic send_blob(input logic [SLOT_W-1:0]  slot,
                             input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y,
                             input logic               alive);
        blob_ch.valid      <= 1'b1;
        blob_ch.blob_slot  <= slot;
        blob_ch.centroid_x <= x;
        blob_ch.centroid_y <= y;
        blob_ch.blob_alive <= alive;
        @(posedge clk);
        while (!blob_ch.ready)
            @(posedge clk);
        blobs_sent++;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            blob_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every due note word has come back
    task automatic settle();
        blob_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_grid(input logic [COORD_W-1:0] lo_x,
                                input logic [COORD_W-1:0] hi_x,
                                input logic [COORD_W-1:0] lo_y,
                                input logic [COORD_W-1:0] hi_y,
                                input logic [COUNT_W-1:0] cols,
                                input logic [COUNT_W-1:0] rows,
                                input logic [SCALE_W-1:0] col_scl,
                                input logic [SCALE_W-1:0] row_scl);
        settle();
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_reg(REG_GRID_LEFT, CFG_DATA_W'(lo_x));
        write_reg(REG_GRID_RIGHT, CFG_DATA_W'(hi_x));
        write_reg(REG_GRID_TOP, CFG_DATA_W'(lo_y));
        write_reg(REG_GRID_BOTTOM, CFG_DATA_W'(hi_y));
        write_reg(REG_COLUMN_COUNT, CFG_DATA_W'(cols));
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
        write_reg(REG_COLUMN_SCALE, col_scl);
        write_reg(REG_ROW_SCALE, row_scl);
        cfg_ch.valid <= 1'b0;
        g_left   = int'(lo_x);
        g_right  = int'(hi_x);
        g_top    = int'(lo_y);
        g_bottom = int'(hi_y);
    endtask

    // random rectangle with scales that spread the keys over it, sometimes overshooting
    // so that the far edge lands on the clamped last column or row
    task automatic random_grid(input logic [COUNT_W-1:0] col_raw,
                               input logic [COUNT_W-1:0] row_raw,
                               input int                 col_keys,
                               input int                 row_keys);
        int lx, hx, ly, hy;
        int cs, rs;
        lx = int'($urandom_range(0, 16'hA000));
        hx = int'($urandom_range(lx + 2, 16'hFFFF));
        ly = int'($urandom_range(0, 16'hA000));
        hy = int'($urandom_range(ly + 2, 16'hFFFF));
        cs = (col_keys << FRAC_W) / (hx - lx);
        rs = (row_keys << FRAC_W) / (hy - ly);
        if ($urandom_range(0, 3) == 0)
            cs = cs + int'($urandom_range(1, 4096));
        if ($urandom_range(0, 3) == 0)
            rs = rs + int'($urandom_range(1, 4096));
        program_grid(COORD_W'(lx), COORD_W'(hx), COORD_W'(ly), COORD_W'(hy),
                     col_raw, row_raw, SCALE_W'(cs), SCALE_W'(rs));
    endtask

    function automatic int pick_x();
        return int'($urandom_range(g_left + 1, g_right - 1));
    endfunction

    function automatic int pick_y();
        return int'($urandom_range(g_top + 1, g_bottom - 1));
    endfunction

    // touch, slide over a few keys (sometimes staying put), then mostly lift inside
    task automatic play_gesture();
        logic [SLOT_W-1:0] slot;
        int moves;
        int x, y;
        slot  = SLOT_W'($urandom_range(0, BLOB_SLOTS - 1));
        x     = pick_x();
        y     = pick_y();
        moves = int'($urandom_range(0, 5));
        send_blob(slot, COORD_W'(x), COORD_W'(y), 1'b1);
        repeat (moves)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                x = pick_x();
                y = pick_y();
            end
            send_blob(slot, COORD_W'(x), COORD_W'(y), 1'b1);
        end
        case ($urandom_range(0, 7))
            0: ;                                     // finger stays down
            // lift on the edge, slot keeps its key
            1: send_blob(slot, COORD_W'(g_left), COORD_W'(y), 1'b0);
            default: send_blob(slot, COORD_W'(pick_x()), COORD_W'(pick_y()), 1'b0);
        endcase
    endtask

    task automatic noise_blob();
        send_blob(SLOT_W'($urandom_range(0, BLOB_SLOTS - 1)),
                  COORD_W'($urandom_range(0, 16'hFFFF)),
                  COORD_W'($urandom_range(0, 16'hFFFF)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic random_phase(input int words, input bit with_hold, input bit gestures);
        int stop_at;
        bit hold_done;
        stop_at   = blobs_sent + words;
        hold_done = 1'b0;
        while (blobs_sent < stop_at)
        begin
            // receiver goes quiet while the sender keeps pushing, fills the pipe
            if (with_hold && !hold_done && blobs_sent >= stop_at - words / 2)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!gestures || $urandom_range(0, 4) == 0)
                noise_blob();
            else
                play_gesture();
        end
    endtask

    initial
    begin
        int keys_x, keys_y;
        blob_ch.valid      <= 1'b0;
        blob_ch.blob_slot  <= '0;
        blob_ch.centroid_x <= '0;
        blob_ch.centroid_y <= '0;
        blob_ch.blob_alive <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_GRID_LEFT;
        cfg_ch.data        <= '0;
        rst_n              <= 1'b0;
        tx_gaps      = 1'b1;
        rx_gaps      = 1'b1;
        hold_request = 1'b0;
        blobs_sent   = 0;
        g_left   = 0;
        g_right  = 16'hFFFF;
        g_top    = 0;
        g_bottom = 16'hFFFF;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: whole plane is one key, edges excluded
        send_blob(4'd3, 16'h8000, 16'h8000, 1'b1);
        send_blob(4'd3, 16'h0000, 16'h8000, 1'b0);
        send_blob(4'd3, 16'hFFFF, 16'hFFFF, 1'b0);
        send_blob(4'd3, 16'h0001, 16'hFFFE, 1'b0);

        // 16 x 16 keys over 0x1000..0x9000, one key every 0x800
        program_grid(16'h1000, 16'h9000, 16'h1000, 16'h9000, 5'd16, 5'd16, 24'd32, 24'd32);
        send_blob(4'd0, 16'h1001, 16'h1001, 1'b1);   // first key
        send_blob(4'd0, 16'h1001, 16'h1001, 1'b1);   // same key, silent
        send_blob(4'd0, 16'h8FFF, 16'h8FFF, 1'b1);   // off then on at the last key
        send_blob(4'd0, 16'h1000, 16'h5000, 1'b1);   // each edge is outside
        send_blob(4'd0, 16'h9000, 16'h5000, 1'b1);
        send_blob(4'd0, 16'h5000, 16'h1000, 1'b1);
        send_blob(4'd0, 16'h5000, 16'h9000, 1'b1);
        send_blob(4'd15, 16'h8FFF, 16'h1001, 1'b1);  // end of the first row
        send_blob(4'd15, 16'h1001, 16'h8FFF, 1'b1);  // start of the last row
        send_blob(4'd0, 16'h5000, 16'h5000, 1'b0);   // lift with a key held
        send_blob(4'd0, 16'h5000, 16'h5000, 1'b0);   // lift with nothing held
        send_blob(4'd15, 16'hFFFF, 16'hFFFF, 1'b0);  // lift outside keeps the key
        send_blob(4'd15, 16'h0000, 16'h0000, 1'b0);
        send_blob(4'd7, 16'h5000, 16'h5000, 1'b0);
        send_blob(4'd15, 16'h2000, 16'h2000, 1'b0);

        // matched grid with both sides idling and the long hold-off
        keys_x = int'($urandom_range(1, 16));
        keys_y = int'($urandom_range(1, 16));
        random_grid(COUNT_W'(keys_x), COUNT_W'(keys_y), keys_x, keys_y);
        random_phase(200, 1'b1, 1'b1);

        // extremes: full plane, column count too big, row count zero, scales at the ends
        program_grid(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 5'd31, 5'd0,
                     24'hFFFFFF, 24'h000000);
        random_phase(120, 1'b0, 1'b1);

        // count clamps the other way round
        random_grid(5'd0, 5'd31, 1, 16);
        random_phase(120, 1'b0, 1'b1);

        // empty rectangles, nothing gets in
        program_grid(16'h8000, 16'h8000, 16'h2000, 16'h1000, 5'd4, 5'd4, 24'd64, 24'd64);
        random_phase(40, 1'b0, 1'b0);

        keys_x = int'($urandom_range(1, 16));
        keys_y = int'($urandom_range(1, 16));
        random_grid(COUNT_W'(keys_x), COUNT_W'(keys_y), keys_x, keys_y);
        random_phase(160, 1'b0, 1'b1);

        // last stretch at full rate on both sides
        keys_x = int'($urandom_range(1, 16));
        keys_y = int'($urandom_range(1, 16));
        random_grid(COUNT_W'(keys_x), COUNT_W'(keys_y), keys_x, keys_y);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_phase(200, 1'b0, 1'b1);

        settle();
        if (mismatch_count == 0 && due_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
